FILE: sv/mim_pkg.sv
// ----------------------------------------------------------------------------
// mim_pkg
// Shared widths, register map and pipeline side-band types for the mapper.
// ----------------------------------------------------------------------------
package mim_pkg;

    localparam int LENGTH_BITS = 21;
    localparam int INDEX_BITS  = 32;
    localparam int POS_BITS    = 32;
    localparam int KW_BITS     = 11;
    localparam int SHIFT_BITS  = KW_BITS - 1;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam int DIV_STEPS   = POS_BITS + 1;
    localparam int DVD_BITS    = LENGTH_BITS + DIV_STEPS;
    localparam int PROD_BITS   = 2 * LENGTH_BITS;
    localparam int TURN_BITS   = DIV_STEPS + 2;
    localparam int TM_BITS     = TURN_BITS + LENGTH_BITS + 1;
    localparam int RES_BITS    = TM_BITS + 1;

    typedef enum logic [1:0] {
        REG_FINE_LENGTH   = 2'd0,
        REG_COARSE_LENGTH = 2'd1,
        REG_KERNEL_WIDTH  = 2'd2,
        REG_CIRCULAR      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] fine_length;
        logic [LENGTH_BITS-1:0] coarse_length;
        logic [KW_BITS-1:0]     kernel_width;
        logic                   circular;
    } cfg_t;

    typedef struct packed {
        logic                     cfg_err;
        logic                     circ;
        logic                     neg;
        logic                     zero;
        logic [SHIFT_BITS-1:0]    shift_add;
        logic [LENGTH_BITS-1:0]   div_b;
        logic [LENGTH_BITS-1:0]   mul_a;
        logic [LENGTH_BITS-1:0]   lin_x;
        logic signed [TM_BITS-1:0] tm;
    } side_t;

endpackage

FILE: sv/mim_front.sv
// ----------------------------------------------------------------------------
// mim_front
// Input stage: kernel shift, configuration check, linear clip and the
// selection of divisor and scale factor for the divider chain.
// ----------------------------------------------------------------------------
module mim_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           enable,
    input  logic                           in_valid,
    input  logic                           command,
    input  logic signed [mim_pkg::POS_BITS-1:0] position,
    input  mim_pkg::cfg_t                  cfg,
    output logic                           out_valid,
    output logic [mim_pkg::DVD_BITS-1:0]   out_dividend,
    output logic [mim_pkg::LENGTH_BITS-1:0] out_divisor,
    output mim_pkg::side_t                 out_side
);
    import mim_pkg::*;

    logic [SHIFT_BITS-1:0]       shift;
    logic signed [POS_BITS:0]    x;
    logic [POS_BITS:0]           mag;
    logic [LENGTH_BITS-1:0]      xmax;
    logic [LENGTH_BITS-1:0]      nc_m1;
    logic [LENGTH_BITS-1:0]      lin_hi;
    logic [LENGTH_BITS-1:0]      lin_m;
    logic [LENGTH_BITS-1:0]      nsrc;
    logic [LENGTH_BITS-1:0]      ndst;
    logic [LENGTH_BITS-1:0]      xc;
    logic                        err;
    side_t                       side_next;
    logic [DVD_BITS-1:0]         dividend_next;
    logic                        valid_reg;
    logic [DVD_BITS-1:0]         dividend_reg;
    side_t                       side_reg;

    always_comb
    begin
        shift  = (cfg.kernel_width == '0) ? '0
                 : SHIFT_BITS'((cfg.kernel_width - KW_BITS'(1)) >> 1);
        x      = command ? (POS_BITS+1)'(position)
                 : (POS_BITS+1)'(position) - $signed({{(POS_BITS+1-SHIFT_BITS){1'b0}}, shift});
        mag    = x[POS_BITS] ? (POS_BITS+1)'(-x) : (POS_BITS+1)'(x);
        err    = (cfg.fine_length < LENGTH_BITS'(cfg.kernel_width))
                 || (cfg.fine_length == '0) || (cfg.coarse_length == '0);
        xmax   = cfg.fine_length - LENGTH_BITS'(cfg.kernel_width);
        nc_m1  = cfg.coarse_length - LENGTH_BITS'(1);
        lin_hi = command ? nc_m1 : xmax;
        lin_m  = command ? xmax : nc_m1;
        nsrc   = command ? cfg.coarse_length : cfg.fine_length;
        ndst   = command ? cfg.fine_length : cfg.coarse_length;
        if (x[POS_BITS])
            xc = '0;
        else if (x > $signed({{(POS_BITS+1-LENGTH_BITS){1'b0}}, lin_hi}))
            xc = lin_hi;
        else
            xc = x[LENGTH_BITS-1:0];

        side_next.cfg_err   = err;
        side_next.circ      = cfg.circular;
        side_next.neg       = x[POS_BITS];
        side_next.zero      = !cfg.circular && (lin_hi == '0);
        side_next.shift_add = command ? shift : '0;
        side_next.div_b     = cfg.circular ? nsrc : lin_hi;
        side_next.mul_a     = cfg.circular ? ndst : lin_m;
        side_next.lin_x     = xc;
        side_next.tm        = '0;
        dividend_next       = cfg.circular ? DVD_BITS'(mag) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (enable)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            dividend_reg <= dividend_next;
            side_reg     <= side_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_dividend = dividend_reg;
    assign out_divisor  = side_reg.div_b;
    assign out_side     = side_reg;

endmodule

FILE: sv/mim_divider.sv
// ----------------------------------------------------------------------------
// mim_divider
// Restoring divider, one quotient bit per register stage; the side-band
// word travels alongside each step.
// ----------------------------------------------------------------------------
module mim_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enable,
    input  logic                            in_valid,
    input  logic [mim_pkg::DVD_BITS-1:0]    dividend,
    input  logic [mim_pkg::LENGTH_BITS-1:0] divisor,
    input  mim_pkg::side_t                  in_side,
    output logic                            out_valid,
    output logic [mim_pkg::DIV_STEPS-1:0]   quotient,
    output logic [mim_pkg::LENGTH_BITS-1:0] remainder,
    output mim_pkg::side_t                  out_side
);
    import mim_pkg::*;

    logic                   valid_reg [0:DIV_STEPS-1];
    logic [LENGTH_BITS-1:0] rem_reg   [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0]   low_reg   [0:DIV_STEPS-1];
    logic [LENGTH_BITS-1:0] dvs_reg   [0:DIV_STEPS-1];
    side_t                  side_reg  [0:DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic                   cur_valid;
        logic [LENGTH_BITS-1:0] cur_rem;
        logic [DIV_STEPS-1:0]   cur_low;
        logic [LENGTH_BITS-1:0] cur_dvs;
        side_t                  cur_side;
        logic [LENGTH_BITS:0]   trial;
        logic [LENGTH_BITS+1:0] diff;
        logic                   ge;

        if (k == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem   = dividend[DVD_BITS-1:DIV_STEPS];
            assign cur_low   = dividend[DIV_STEPS-1:0];
            assign cur_dvs   = divisor;
            assign cur_side  = in_side;
        end
        else
        begin : g_next
            assign cur_valid = valid_reg[k-1];
            assign cur_rem   = rem_reg[k-1];
            assign cur_low   = low_reg[k-1];
            assign cur_dvs   = dvs_reg[k-1];
            assign cur_side  = side_reg[k-1];
        end

        assign trial = {cur_rem, cur_low[DIV_STEPS-1]};
        assign diff  = {1'b0, trial} - {2'b00, cur_dvs};
        assign ge    = !diff[LENGTH_BITS+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (enable)
                valid_reg[k] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                rem_reg[k]  <= ge ? diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
                low_reg[k]  <= {cur_low[DIV_STEPS-2:0], ge};
                dvs_reg[k]  <= cur_dvs;
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quotient  = low_reg[DIV_STEPS-1];
    assign remainder = rem_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

FILE: sv/mim_fixmul.sv
// ----------------------------------------------------------------------------
// mim_fixmul
// Two stages between the dividers: floor correction of turns and residue,
// then the scale product and the restored whole turns.
// ----------------------------------------------------------------------------
module mim_fixmul
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enable,
    input  logic                            in_valid,
    input  logic [mim_pkg::DIV_STEPS-1:0]   quotient,
    input  logic [mim_pkg::LENGTH_BITS-1:0] remainder,
    input  mim_pkg::side_t                  in_side,
    output logic                            out_valid,
    output logic [mim_pkg::DVD_BITS-1:0]    out_dividend,
    output logic [mim_pkg::LENGTH_BITS-1:0] out_divisor,
    output mim_pkg::side_t                  out_side
);
    import mim_pkg::*;

    logic                         nz;
    logic signed [TURN_BITS-1:0]  turns_next;
    logic [LENGTH_BITS-1:0]       rfix_next;
    logic                         v1_reg;
    logic signed [TURN_BITS-1:0]  turns_reg;
    logic [LENGTH_BITS-1:0]       rfix_reg;
    side_t                        s1_reg;
    logic [LENGTH_BITS-1:0]       mul_b;
    logic [PROD_BITS-1:0]         prod;
    logic signed [TM_BITS-1:0]    tm_prod;
    logic                         v2_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    side_t                        s2_next;
    side_t                        s2_reg;

    always_comb
    begin
        nz = (remainder != '0);
        if (in_side.neg)
            turns_next = -($signed({2'b00, quotient}) + $signed(TURN_BITS'(nz)));
        else
            turns_next = $signed({2'b00, quotient});
        rfix_next = (in_side.neg && nz) ? in_side.div_b - remainder : remainder;
    end

    always_comb
    begin
        mul_b   = s1_reg.circ ? rfix_reg : s1_reg.lin_x;
        prod    = PROD_BITS'(s1_reg.mul_a) * PROD_BITS'(mul_b);
        tm_prod = TM_BITS'(turns_reg) * $signed({{(TM_BITS-LENGTH_BITS){1'b0}}, s1_reg.mul_a});
        s2_next = s1_reg;
        s2_next.tm = s1_reg.circ ? tm_prod : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            turns_reg <= turns_next;
            rfix_reg  <= rfix_next;
            s1_reg    <= in_side;
            prod_reg  <= prod;
            s2_reg    <= s2_next;
        end
    end

    assign out_valid    = v2_reg;
    assign out_dividend = DVD_BITS'(prod_reg);
    assign out_divisor  = s2_reg.div_b;
    assign out_side     = s2_reg;

endmodule

FILE: sv/multiscale_index_mapper.sv
// ----------------------------------------------------------------------------
// multiscale_index_mapper
// Maps a signed position between fine and coarse resolutions of a sequence.
// ----------------------------------------------------------------------------
// Fully pipelined: one word is taken every cycle unless the output stalls.
// Each word passes the input stage, two 33-step restoring divider pipelines
// (floor turns and residue, then the scaled residue) with the correction and
// multiply stages between them, and the output stage. A stall at the output
// holds the whole pipeline. Configuration registers are read directly by the
// input stage; write them only while no word is in flight.
// ----------------------------------------------------------------------------
module multiscale_index_mapper
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mim_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [mim_pkg::DATA_BITS-1:0]   pwdata,
    output logic [mim_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] position
    input  logic                            s_tuser,   // [0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] mapped_position
    output logic [1:0]                      m_tuser    // [0] config_error, [1] saturated
);
    import mim_pkg::*;

    localparam logic signed [RES_BITS-1:0] SAT_HI =
        RES_BITS'((64'd1 << (INDEX_BITS - 1)) - 64'd1);
    localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);

    cfg_t                    cfg_reg;
    logic                    adv;
    logic                    wr;
    reg_index_t              widx;

    logic                    f_valid;
    logic [DVD_BITS-1:0]     f_dividend;
    logic [LENGTH_BITS-1:0]  f_divisor;
    side_t                   f_side;
    logic                    d1_valid;
    logic [DIV_STEPS-1:0]    d1_quot;
    logic [LENGTH_BITS-1:0]  d1_rem;
    side_t                   d1_side;
    logic                    x_valid;
    logic [DVD_BITS-1:0]     x_dividend;
    logic [LENGTH_BITS-1:0]  x_divisor;
    side_t                   x_side;
    logic                    d2_valid;
    logic [DIV_STEPS-1:0]    d2_quot;
    logic [LENGTH_BITS-1:0]  d2_rem;
    side_t                   d2_side;

    logic signed [RES_BITS-1:0] res;
    logic                    sat_next;
    logic [31:0]             data_next;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign widx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fine_length   <= LENGTH_BITS'(1);
            cfg_reg.coarse_length <= LENGTH_BITS'(1);
            cfg_reg.kernel_width  <= KW_BITS'(1);
            cfg_reg.circular      <= 1'b0;
        end
        else if (wr)
        begin
            unique case (widx)
                REG_FINE_LENGTH:   cfg_reg.fine_length   <= pwdata[LENGTH_BITS-1:0];
                REG_COARSE_LENGTH: cfg_reg.coarse_length <= pwdata[LENGTH_BITS-1:0];
                REG_KERNEL_WIDTH:  cfg_reg.kernel_width  <= pwdata[KW_BITS-1:0];
                REG_CIRCULAR:      cfg_reg.circular      <= pwdata[0];
                default:           cfg_reg.circular      <= cfg_reg.circular;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_FINE_LENGTH:   prdata = DATA_BITS'(cfg_reg.fine_length);
            REG_COARSE_LENGTH: prdata = DATA_BITS'(cfg_reg.coarse_length);
            REG_KERNEL_WIDTH:  prdata = DATA_BITS'(cfg_reg.kernel_width);
            REG_CIRCULAR:      prdata = DATA_BITS'(cfg_reg.circular);
            default:           prdata = '0;
        endcase
    end

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    mim_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (adv),
        .in_valid     (s_tvalid),
        .command      (s_tuser),
        .position     ($signed(s_tdata)),
        .cfg          (cfg_reg),
        .out_valid    (f_valid),
        .out_dividend (f_dividend),
        .out_divisor  (f_divisor),
        .out_side     (f_side)
    );

    mim_divider u_div_turns
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (adv),
        .in_valid  (f_valid),
        .dividend  (f_dividend),
        .divisor   (f_divisor),
        .in_side   (f_side),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .remainder (d1_rem),
        .out_side  (d1_side)
    );

    mim_fixmul u_fixmul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (adv),
        .in_valid     (d1_valid),
        .quotient     (d1_quot),
        .remainder    (d1_rem),
        .in_side      (d1_side),
        .out_valid    (x_valid),
        .out_dividend (x_dividend),
        .out_divisor  (x_divisor),
        .out_side     (x_side)
    );

    mim_divider u_div_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (adv),
        .in_valid  (x_valid),
        .dividend  (x_dividend),
        .divisor   (x_divisor),
        .in_side   (x_side),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .remainder (d2_rem),
        .out_side  (d2_side)
    );

    always_comb
    begin
        res = (d2_side.zero ? RES_BITS'(0) : $signed({{(RES_BITS-DIV_STEPS){1'b0}}, d2_quot}))
              + RES_BITS'(d2_side.tm)
              + $signed({{(RES_BITS-SHIFT_BITS){1'b0}}, d2_side.shift_add});
        sat_next = 1'b0;
        if (res > SAT_HI)
        begin
            res      = SAT_HI;
            sat_next = 1'b1;
        end
        else if (res < SAT_LO)
        begin
            res      = SAT_LO;
            sat_next = 1'b1;
        end
        data_next = res[31:0];
        if (d2_side.cfg_err)
        begin
            data_next = '0;
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= data_next;
            m_tuser_reg <= {sat_next, d2_side.cfg_err};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    unused_rem_a: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    err_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0 && !m_tuser[1]))
        else $error("configuration error word carries data or saturation");

    sat_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == SAT_HI[31:0] || m_tdata == SAT_LO[31:0]))
        else $error("saturated word is not at a range bound");

    stall_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser) && m_tvalid))
        else $error("stalled output word changed");

    logic [LENGTH_BITS-1:0] rem_unused;
    assign rem_unused = d2_rem;

    rem_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        (d2_valid && d2_side.div_b != '0 && !d2_side.cfg_err) |-> (rem_unused < d2_side.div_b))
        else $error("scale divider remainder out of range");

endmodule
